/* design/rgbsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbsp_pkg
// Shared types and constants of the polynomial spectral reconstruction unit.
// ----------------------------------------------------------------------------
package rgbsp_pkg;

	localparam int TERMS  = 36;
	localparam int TERM_W = 6;
	localparam int COEF_W = 32;
	localparam int MONO_W = 32;
	localparam int PROD_W = COEF_W + MONO_W + 1;
	localparam int ACC_W  = 72;

	localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(TERMS - 1);

	// Request codes carried by req_type.
	localparam logic REQ_LOAD    = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;

	// Exponents of one monomial R^r G^g B^b.
	typedef struct packed {
		logic [2:0] r;
		logic [2:0] g;
		logic [2:0] b;
	} exp_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic              start;
		logic              pow_step;
		logic [2:0]        pow_k;
		logic              issue;
		logic [TERM_W-1:0] term;
	} ctl_t;

	// Status from the datapath back to the sequencer.
	typedef struct packed {
		logic              busy;
		logic [COEF_W-1:0] value;
		logic              sat;
	} stat_t;

	function automatic exp_t mono_exp(input logic [TERM_W-1:0] term);
		exp_t e;
		e = '{r: 3'd0, g: 3'd0, b: 3'd0};
		case (term)
			6'd2:  e = '{r: 3'd1, g: 3'd0, b: 3'd0};
			6'd3:  e = '{r: 3'd0, g: 3'd1, b: 3'd0};
			6'd4:  e = '{r: 3'd0, g: 3'd0, b: 3'd1};
			6'd5:  e = '{r: 3'd2, g: 3'd0, b: 3'd0};
			6'd6:  e = '{r: 3'd1, g: 3'd1, b: 3'd0};
			6'd7:  e = '{r: 3'd1, g: 3'd0, b: 3'd1};
			6'd8:  e = '{r: 3'd0, g: 3'd2, b: 3'd0};
			6'd9:  e = '{r: 3'd0, g: 3'd1, b: 3'd1};
			6'd10: e = '{r: 3'd0, g: 3'd0, b: 3'd2};
			6'd11: e = '{r: 3'd3, g: 3'd0, b: 3'd0};
			6'd12: e = '{r: 3'd2, g: 3'd1, b: 3'd0};
			6'd13: e = '{r: 3'd2, g: 3'd0, b: 3'd1};
			6'd14: e = '{r: 3'd1, g: 3'd2, b: 3'd0};
			6'd15: e = '{r: 3'd1, g: 3'd1, b: 3'd1};
			6'd16: e = '{r: 3'd1, g: 3'd0, b: 3'd2};
			6'd17: e = '{r: 3'd0, g: 3'd3, b: 3'd0};
			6'd18: e = '{r: 3'd0, g: 3'd2, b: 3'd1};
			6'd19: e = '{r: 3'd0, g: 3'd1, b: 3'd2};
			6'd20: e = '{r: 3'd0, g: 3'd0, b: 3'd3};
			6'd21: e = '{r: 3'd4, g: 3'd0, b: 3'd0};
			6'd22: e = '{r: 3'd3, g: 3'd1, b: 3'd0};
			6'd23: e = '{r: 3'd3, g: 3'd0, b: 3'd1};
			6'd24: e = '{r: 3'd2, g: 3'd2, b: 3'd0};
			6'd25: e = '{r: 3'd2, g: 3'd1, b: 3'd1};
			6'd26: e = '{r: 3'd2, g: 3'd0, b: 3'd2};
			6'd27: e = '{r: 3'd1, g: 3'd3, b: 3'd0};
			6'd28: e = '{r: 3'd1, g: 3'd2, b: 3'd1};
			6'd29: e = '{r: 3'd1, g: 3'd1, b: 3'd2};
			6'd30: e = '{r: 3'd1, g: 3'd0, b: 3'd3};
			6'd31: e = '{r: 3'd0, g: 3'd4, b: 3'd0};
			6'd32: e = '{r: 3'd0, g: 3'd3, b: 3'd1};
			6'd33: e = '{r: 3'd0, g: 3'd2, b: 3'd2};
			6'd34: e = '{r: 3'd0, g: 3'd1, b: 3'd3};
			6'd35: e = '{r: 3'd0, g: 3'd0, b: 3'd4};
			default: e = '{r: 3'd0, g: 3'd0, b: 3'd0};
		endcase
		return e;
	endfunction

endpackage

/* design/rgbsp_coef_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbsp_coef_mem
// Coefficient store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rgbsp_coef_mem #(
	parameter int DEPTH  = 18432,
	parameter int ADDR_W = 15
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [ADDR_W-1:0]              waddr,
	input  logic [rgbsp_pkg::COEF_W-1:0]   wdata,
	input  logic                           re,
	input  logic [ADDR_W-1:0]              raddr,
	output logic [rgbsp_pkg::COEF_W-1:0]   rdata
);

	logic [rgbsp_pkg::COEF_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/rgbsp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbsp_datapath
// Sample powers, monomial pipeline, multiply-accumulate and output rounding with saturation.
// ----------------------------------------------------------------------------
module rgbsp_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rgbsp_pkg::ctl_t               ctl,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	input  logic [rgbsp_pkg::COEF_W-1:0]  rdata,
	output rgbsp_pkg::stat_t              stat
);

	localparam int MW = rgbsp_pkg::MONO_W;
	localparam int AW = rgbsp_pkg::ACC_W;

	// Powers 1 to 4 of each sample, entry k-1 holds power k.
	logic [3:0][MW-1:0] pr_q, pg_q, pb_q;
	logic [7:0]         xr_q, xg_q, xb_q;

	logic                           v_s1, v_s2, v_s3;
	logic [MW-1:0]                  m1_s1;
	logic [2:0]                     eb_s1;
	logic [MW-1:0]                  mono_s2;
	logic [rgbsp_pkg::COEF_W-1:0]   coef_s2;
	logic signed [rgbsp_pkg::PROD_W-1:0] prod_s3;
	logic signed [AW-1:0]           acc_q;

	rgbsp_pkg::exp_t     ex;
	logic [MW-1:0]       m1_d;
	logic [MW-1:0]       mono_d;
	logic signed [rgbsp_pkg::PROD_W-1:0] prod_d;
	logic signed [AW-1:0] rnd;
	logic [AW-40:0]      upper;
	logic [1:0]          rd_idx, wr_idx;

	function automatic logic [MW-1:0] pick(input logic [3:0][MW-1:0] p, input logic [2:0] e);
		logic [MW-1:0] v;
		v = MW'(1);
		case (e)
			3'd1:    v = p[0];
			3'd2:    v = p[1];
			3'd3:    v = p[2];
			3'd4:    v = p[3];
			default: v = MW'(1);
		endcase
		return v;
	endfunction

	assign wr_idx = 2'(ctl.pow_k - 3'd1);
	assign rd_idx = 2'(ctl.pow_k - 3'd2);

	// Powers are built one degree per step from the one below.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			xr_q     <= red;
			xg_q     <= green;
			xb_q     <= blue;
			pr_q[0]  <= MW'(red);
			pg_q[0]  <= MW'(green);
			pb_q[0]  <= MW'(blue);
		end else if (ctl.pow_step) begin
			pr_q[wr_idx] <= MW'(pr_q[rd_idx][23:0]) * MW'(xr_q);
			pg_q[wr_idx] <= MW'(pg_q[rd_idx][23:0]) * MW'(xg_q);
			pb_q[wr_idx] <= MW'(pb_q[rd_idx][23:0]) * MW'(xb_q);
		end
	end

	// Total degree is at most four, so every partial monomial fits 32 bits.
	assign ex     = rgbsp_pkg::mono_exp(ctl.term);
	assign m1_d   = MW'(pick(pr_q, ex.r) * pick(pg_q, ex.g));
	assign mono_d = MW'(m1_s1 * pick(pb_q, eb_s1));
	assign prod_d = $signed(coef_s2) * $signed({1'b0, mono_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		m1_s1   <= m1_d;
		eb_s1   <= ex.b;
		mono_s2 <= mono_d;
		coef_s2 <= rdata;
		prod_s3 <= prod_d;
		if (ctl.start) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + AW'(prod_s3);
		end
	end

	// Round to nearest (ties upward), drop eight fraction bits, then saturate.
	assign rnd   = acc_q + AW'(128);
	assign upper = rnd[AW-1:39];

	always_comb begin
		stat.busy  = v_s1 | v_s2 | v_s3;
		stat.value = rnd[39:8];
		stat.sat   = 1'b0;
		if (!rnd[AW-1] && (|upper)) begin
			stat.value = 32'h7FFF_FFFF;
			stat.sat   = 1'b1;
		end else if (rnd[AW-1] && !(&upper)) begin
			stat.value = 32'h8000_0000;
			stat.sat   = 1'b1;
		end
	end

endmodule

/* design/rgb_to_spectrum_poly4_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_spectrum_poly4_unit
// Degree-4 polynomial spectral reconstruction of one RGB pixel per request.
// ----------------------------------------------------------------------------
// A load transfer (req_type = 0) writes one signed Q8.24 coefficient into the
// table at slot wave_index, position coef_index. A compute transfer
// (req_type = 1) evaluates the 36-term polynomial for the pixel at slot
// wave_index and returns one Q16.16 value, rounded to nearest with ties
// upward and saturated, with saturated set when clipping occurred. A compute
// occupies the unit while the sample powers are built; the 36 coefficients
// are then read through the read port of the coefficient memory one per
// cycle, which sets the rate; then the multiply pipeline drains and the result
// is posted. The result sits in an output register, so the next request is
// taken while it waits to be collected. Loads or computes whose slot is at
// or beyond WAVES, and loads whose coefficient position is beyond 35, are
// consumed without effect. Every coefficient a compute reads must have been
// loaded; the table has no reset.
// ----------------------------------------------------------------------------
module rgb_to_spectrum_poly4_unit #(
	parameter int WAVES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [8:0]  wave_index,
	input  logic [5:0]  coef_index,
	input  logic signed [31:0] coef_value,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [8:0]  wave_out,
	output logic signed [31:0] spectral_value,
	output logic        saturated
);

	localparam int DEPTH  = WAVES * rgbsp_pkg::TERMS;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POWER,
		ST_ISSUE,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [2:0]                      pow_k_q;
	logic [rgbsp_pkg::TERM_W-1:0]    term_q;
	logic [ADDR_W-1:0]               addr_q;
	logic [8:0]                      wave_q;
	logic                            out_valid_q;

	logic                            accept, wave_ok, coef_ok, mem_we, out_load;
	logic [ADDR_W-1:0]               base_addr, waddr;
	logic [rgbsp_pkg::COEF_W-1:0]    rdata;
	rgbsp_pkg::ctl_t                 ctl;
	rgbsp_pkg::stat_t                stat;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign wave_ok   = (32'(wave_index) < WAVES);
	assign coef_ok   = (32'(coef_index) < rgbsp_pkg::TERMS);
	assign base_addr = ADDR_W'(ADDR_W'(wave_index) * ADDR_W'(rgbsp_pkg::TERMS));
	assign waddr     = ADDR_W'(base_addr + ADDR_W'(coef_index));
	assign mem_we    = accept && wave_ok && coef_ok && (req_type == rgbsp_pkg::REQ_LOAD);

	// The result register is loaded only when it is empty or being emptied.
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		ctl.start    = accept && wave_ok && (req_type == rgbsp_pkg::REQ_COMPUTE);
		ctl.pow_step = (state_q == ST_POWER);
		ctl.pow_k    = pow_k_q;
		ctl.issue    = (state_q == ST_ISSUE);
		ctl.term     = term_q;
	end

	rgbsp_coef_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (coef_value),
		.re    (ctl.issue),
		.raddr (addr_q),
		.rdata (rdata)
	);

	rgbsp_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.rdata  (rdata),
		.stat   (stat)
	);

	// Sequencer: power build, one coefficient read per cycle, drain, post.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pow_k_q     <= 3'd2;
			term_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= ST_POWER;
						pow_k_q <= 3'd2;
					end
				end
				ST_POWER: begin
					pow_k_q <= pow_k_q + 3'd1;
					if (pow_k_q == 3'd4) begin
						state_q <= ST_ISSUE;
						term_q  <= '0;
					end
				end
				ST_ISSUE: begin
					term_q <= term_q + 1'b1;
					if (term_q == rgbsp_pkg::LAST_TERM) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stat.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			wave_q <= wave_index;
			addr_q <= base_addr;
		end else if (ctl.issue) begin
			addr_q <= addr_q + 1'b1;
		end
		if (out_load) begin
			wave_out       <= wave_q;
			spectral_value <= stat.value;
			saturated      <= stat.sat;
		end
	end

	assign out_valid = out_valid_q;

	// The accumulator must have absorbed every product before it is posted.
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> !stat.busy)
		else $error("result posted while products are still in flight");

	// A new request must not be taken while the pipeline still works.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.busy)
		else $error("request taken while pipeline busy");

	// A posted result must not overwrite one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// The read phase ends after the read of the last term, so 36 reads follow each compute start.
	a_issue_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE && term_q == rgbsp_pkg::LAST_TERM) |=> (state_q == ST_DRAIN))
		else $error("coefficient read sequence has wrong length");

endmodule
